// File: hw/rtl/nbt_pkg.sv
// ----------------------------------------------------------------------------
// nbt_pkg
// Shared types and constants for the neighbor table: command beat layout,
// table entry layout and fixed field widths.
// ----------------------------------------------------------------------------
package nbt_pkg;

    localparam int ID_W    = 8;
    localparam int TICK_W  = 32;
    localparam int BYTE_W  = 8;
    localparam int TMO_W   = 16;

    localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd32;

    // Depth of the command queue between front and back; a power of two.
    localparam int QUEUE_DEPTH = 2;

    localparam logic OP_MSG = 1'b0;
    localparam logic OP_AGE = 1'b1;

    typedef enum logic [0:0] {
        CMD_MSG = 1'b0,
        CMD_AGE = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [TICK_W-1:0]   now;
        logic [ID_W-1:0]     sender_id;
        logic [BYTE_W-1:0]   sender_neighbors;
        logic [BYTE_W-1:0]   link_distance;
    } cmd_t;

    typedef struct packed {
        logic [ID_W-1:0]     ident;
        logic [TICK_W-1:0]   stamp;
        logic [BYTE_W-1:0]   distance;
        logic [BYTE_W-1:0]   reported;
    } entry_t;

endpackage

// File: hw/rtl/nbt_front.sv
// ----------------------------------------------------------------------------
// nbt_front
// Input stage: takes one beat, decodes the opcode into a command kind and
// holds the command until the queue takes it.
// ----------------------------------------------------------------------------
module nbt_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           opcode,
    input  logic [nbt_pkg::TICK_W-1:0]     now,
    input  logic [nbt_pkg::ID_W-1:0]       sender_id,
    input  logic [nbt_pkg::BYTE_W-1:0]     sender_neighbors,
    input  logic [nbt_pkg::BYTE_W-1:0]     link_distance,
    output logic                           push_valid,
    input  logic                           push_ready,
    output nbt_pkg::cmd_t                  push_cmd
);

    logic          hold_valid_reg;
    nbt_pkg::cmd_t hold_cmd_reg;
    nbt_pkg::cmd_t decoded;

    always_comb
    begin
        decoded.kind             = (opcode == nbt_pkg::OP_AGE) ? nbt_pkg::CMD_AGE
                                                              : nbt_pkg::CMD_MSG;
        decoded.now              = now;
        decoded.sender_id        = sender_id;
        decoded.sender_neighbors = sender_neighbors;
        decoded.link_distance    = link_distance;
    end

    assign in_ready   = !hold_valid_reg || push_ready;
    assign push_valid = hold_valid_reg;
    assign push_cmd   = hold_cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            hold_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            hold_cmd_reg <= decoded;
        end
    end

endmodule

// File: hw/rtl/nbt_queue.sv
// ----------------------------------------------------------------------------
// nbt_queue
// Short command FIFO between the front stage and the table sequencer.
// ----------------------------------------------------------------------------
module nbt_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  nbt_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output nbt_pkg::cmd_t pop_cmd
);

    localparam int PTR_W = (nbt_pkg::QUEUE_DEPTH > 1) ? $clog2(nbt_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(nbt_pkg::QUEUE_DEPTH + 1);

    nbt_pkg::cmd_t    slot_reg [nbt_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (fill_reg != CNT_W'(nbt_pkg::QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: hw/rtl/nbt_back.sv
// ----------------------------------------------------------------------------
// nbt_back
// Table sequencer: holds the entry memory, runs the search-and-append for a
// message and the top-down aging sweep, and registers one result per command.
// ----------------------------------------------------------------------------
module nbt_back #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [nbt_pkg::TMO_W-1:0]     cfg_wr_data,
    input  logic                          pop_valid,
    output logic                          pop_ready,
    input  nbt_pkg::cmd_t                 pop_cmd,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [$clog2(TABLE_DEPTH+1)-1:0] table_count,
    output logic                          was_present,
    output logic                          was_inserted,
    output logic                          was_dropped,
    output logic [$clog2(TABLE_DEPTH+1)-1:0] removed_count
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = $clog2(TABLE_DEPTH);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MSCAN = 7'b0000010,
        ST_MCMP  = 7'b0000100,
        ST_ASCAN = 7'b0001000,
        ST_ACMP  = 7'b0010000,
        ST_AMOVE = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    nbt_pkg::entry_t mem [TABLE_DEPTH];
    nbt_pkg::entry_t rd_data_reg;

    state_t                    state_reg, state_next;
    nbt_pkg::cmd_t             cmd_reg, cmd_next;
    logic [CNT_W-1:0]          vt_reg, vt_next;
    logic [CNT_W-1:0]          idx_reg, idx_next;
    logic [CNT_W-1:0]          removed_reg, removed_next;
    logic                      present_reg, present_next;
    logic                      inserted_reg, inserted_next;
    logic                      dropped_reg, dropped_next;
    logic [nbt_pkg::TMO_W-1:0] timeout_reg;

    logic                      out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]          out_count_reg;
    logic                      out_present_reg;
    logic                      out_inserted_reg;
    logic                      out_dropped_reg;
    logic [CNT_W-1:0]          out_removed_reg;
    logic                      out_load;

    logic                      mem_we;
    logic [IDX_W-1:0]          mem_waddr;
    nbt_pkg::entry_t           mem_wdata;
    logic [IDX_W-1:0]          rd_addr;
    logic [CNT_W-1:0]          idx_dec;
    logic [CNT_W-1:0]          vt_dec;
    logic [nbt_pkg::TICK_W-1:0] age;
    logic                      aged;

    assign idx_dec = idx_reg - CNT_W'(1);
    assign vt_dec  = vt_reg - CNT_W'(1);
    assign age     = cmd_reg.now - rd_data_reg.stamp;
    assign aged    = age > nbt_pkg::TICK_W'(timeout_reg);

    assign pop_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        vt_next        = vt_reg;
        idx_next       = idx_reg;
        removed_next   = removed_reg;
        present_next   = present_reg;
        inserted_next  = inserted_reg;
        dropped_next   = dropped_reg;
        out_load       = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg[IDX_W-1:0];
        mem_wdata      = rd_data_reg;
        rd_addr        = idx_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    cmd_next      = pop_cmd;
                    removed_next  = '0;
                    present_next  = 1'b0;
                    inserted_next = 1'b0;
                    dropped_next  = 1'b0;
                    if (pop_cmd.kind == nbt_pkg::CMD_AGE)
                    begin
                        idx_next   = vt_reg;
                        state_next = ST_ASCAN;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = ST_MSCAN;
                    end
                end
            end
            ST_MSCAN:
            begin
                if (idx_reg == vt_reg)
                begin
                    // Sender absent: append, or drop on a full table.
                    if (vt_reg != CNT_W'(TABLE_DEPTH))
                    begin
                        mem_we             = 1'b1;
                        mem_waddr          = vt_reg[IDX_W-1:0];
                        mem_wdata.ident    = cmd_reg.sender_id;
                        mem_wdata.stamp    = cmd_reg.now;
                        mem_wdata.distance = cmd_reg.link_distance;
                        mem_wdata.reported = cmd_reg.sender_neighbors;
                        vt_next            = vt_reg + CNT_W'(1);
                        inserted_next      = 1'b1;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_MCMP;
                end
            end
            ST_MCMP:
            begin
                if (rd_data_reg.ident == cmd_reg.sender_id)
                begin
                    present_next = 1'b1;
                    state_next   = ST_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = ST_MSCAN;
                end
            end
            ST_ASCAN:
            begin
                if (idx_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    rd_addr    = idx_dec[IDX_W-1:0];
                    idx_next   = idx_dec;
                    state_next = ST_ACMP;
                end
            end
            ST_ACMP:
            begin
                // Fetch the last valid entry to fill the expired slot.
                rd_addr = vt_dec[IDX_W-1:0];
                if (aged)
                begin
                    state_next = ST_AMOVE;
                end
                else
                begin
                    state_next = ST_ASCAN;
                end
            end
            ST_AMOVE:
            begin
                mem_we       = 1'b1;
                mem_waddr    = idx_reg[IDX_W-1:0];
                mem_wdata    = rd_data_reg;
                vt_next      = vt_dec;
                removed_next = removed_reg + CNT_W'(1);
                state_next   = ST_ASCAN;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            vt_reg        <= '0;
            idx_reg       <= '0;
            removed_reg   <= '0;
            present_reg   <= 1'b0;
            inserted_reg  <= 1'b0;
            dropped_reg   <= 1'b0;
            timeout_reg   <= nbt_pkg::TIMEOUT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vt_reg        <= vt_next;
            idx_reg       <= idx_next;
            removed_reg   <= removed_next;
            present_reg   <= present_next;
            inserted_reg  <= inserted_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                timeout_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (out_load)
        begin
            out_count_reg    <= vt_reg;
            out_present_reg  <= present_reg;
            out_inserted_reg <= inserted_reg;
            out_dropped_reg  <= dropped_reg;
            out_removed_reg  <= removed_reg;
        end
    end

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign out_valid     = out_valid_reg;
    assign table_count   = out_count_reg;
    assign was_present   = out_present_reg;
    assign was_inserted  = out_inserted_reg;
    assign was_dropped   = out_dropped_reg;
    assign removed_count = out_removed_reg;

endmodule

// File: hw/rtl/neighbor_table_with_aging.sv
// Path: the front register, the queue, then the sequencer:
//   a message compares entries in turn and appends or drops on a miss;
//   a sweep checks valid entries from the top down and fills each expired
//   slot with the last valid entry.
// Throughput: one command at a time in the sequencer, set by the single read
//   port of the entry memory; the front and queue keep accepting until full.
// Reset: empty table, timeout 32; entry contents are not cleared.
// ----------------------------------------------------------------------------
// neighbor_table_with_aging
// Neighbor table with search-and-append on messages and timeout-based aging.
// ----------------------------------------------------------------------------
module neighbor_table_with_aging #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [nbt_pkg::TMO_W-1:0]         cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              opcode,
    input  logic [nbt_pkg::TICK_W-1:0]        now,
    input  logic [nbt_pkg::ID_W-1:0]          sender_id,
    input  logic [nbt_pkg::BYTE_W-1:0]        sender_neighbors,
    input  logic [nbt_pkg::BYTE_W-1:0]        link_distance,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]  table_count,
    output logic                              was_present,
    output logic                              was_inserted,
    output logic                              was_dropped,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]  removed_count
);

    logic          push_valid;
    logic          push_ready;
    nbt_pkg::cmd_t push_cmd;
    logic          pop_valid;
    logic          pop_ready;
    nbt_pkg::cmd_t pop_cmd;

    nbt_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .opcode           (opcode),
        .now              (now),
        .sender_id        (sender_id),
        .sender_neighbors (sender_neighbors),
        .link_distance    (link_distance),
        .push_valid       (push_valid),
        .push_ready       (push_ready),
        .push_cmd         (push_cmd)
    );

    nbt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    nbt_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_cmd       (pop_cmd),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .table_count   (table_count),
        .was_present   (was_present),
        .was_inserted  (was_inserted),
        .was_dropped   (was_dropped),
        .removed_count (removed_count)
    );

endmodule

// File: sim/neighbor_table_with_aging_test.sv
// ----------------------------------------------------------------------------
// neighbor_table_with_aging_test
// Self-checking bench for the neighbor table. A directed table of commands
// covers the empty, full and wrap cases. Random traffic then follows under
// several timeout settings, with random gaps on the command side and random
// result-side stalls in all but one setting. Each result beat is compared
// with the row's given beat, else a cycle-free table model in the bench.
// ----------------------------------------------------------------------------
module neighbor_table_with_aging_test;

    localparam int DEPTH      = 16;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int DRAIN_WAIT = 4 * DEPTH + 8;
    localparam int LIMIT      = 400000;
    localparam int PHASES     = 6;
    localparam int PHASE_LEN  = 84;

    typedef struct packed {
        logic [CNT_W-1:0] table_count;
        logic             was_present;
        logic             was_inserted;
        logic             was_dropped;
        logic [CNT_W-1:0] removed_count;
    } table_beat_t;

    typedef struct {
        nbt_pkg::cmd_t cmd;
        bit            typed;
        table_beat_t   want;
    } stim_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [nbt_pkg::TMO_W-1:0]  cfg_wr_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic                       opcode = nbt_pkg::OP_MSG;
    logic [nbt_pkg::TICK_W-1:0] now = '0;
    logic [nbt_pkg::ID_W-1:0]   sender_id = '0;
    logic [nbt_pkg::BYTE_W-1:0] sender_neighbors = '0;
    logic [nbt_pkg::BYTE_W-1:0] link_distance = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [CNT_W-1:0]           table_count;
    logic                       was_present;
    logic                       was_inserted;
    logic                       was_dropped;
    logic [CNT_W-1:0]           removed_count;

    // Model of the table contents
    logic [nbt_pkg::ID_W-1:0]   nb_ident [DEPTH];
    logic [nbt_pkg::TICK_W-1:0] nb_stamp [DEPTH];
    logic [nbt_pkg::BYTE_W-1:0] nb_distance [DEPTH];
    logic [nbt_pkg::BYTE_W-1:0] nb_reported [DEPTH];
    int                         nb_count = 0;
    logic [nbt_pkg::TMO_W-1:0]  age_limit = nbt_pkg::TIMEOUT_RESET;

    table_beat_t                pending_results[$];
    table_beat_t                oldest;
    stim_row_t                  directed_rows[$];
    int                         mismatch_count = 0;
    int                         cycle_count = 0;
    int                         stall_left = 0;
    bit                         source_quiet = 1'b0;
    bit                         sink_quiet = 1'b0;
    logic [nbt_pkg::TICK_W-1:0] tick = '0;

    neighbor_table_with_aging #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .now             (now),
        .sender_id       (sender_id),
        .sender_neighbors(sender_neighbors),
        .link_distance   (link_distance),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .table_count     (table_count),
        .was_present     (was_present),
        .was_inserted    (was_inserted),
        .was_dropped     (was_dropped),
        .removed_count   (removed_count)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic nbt_pkg::cmd_t make_cmd(input nbt_pkg::cmd_kind_t kind,
                                               input logic [nbt_pkg::TICK_W-1:0] t,
                                               input logic [nbt_pkg::ID_W-1:0] id,
                                               input logic [nbt_pkg::BYTE_W-1:0] rep,
                                               input logic [nbt_pkg::BYTE_W-1:0] dist_mm);
        nbt_pkg::cmd_t c;
        c.kind             = kind;
        c.now              = t;
        c.sender_id        = id;
        c.sender_neighbors = rep;
        c.link_distance    = dist_mm;
        return c;
    endfunction

    function automatic table_beat_t make_beat(input int cnt, input bit present,
                                              input bit inserted, input bit dropped,
                                              input int removed);
        table_beat_t b;
        b.table_count   = CNT_W'(cnt);
        b.was_present   = present;
        b.was_inserted  = inserted;
        b.was_dropped   = dropped;
        b.removed_count = CNT_W'(removed);
        return b;
    endfunction

    function automatic void add_row(input nbt_pkg::cmd_t c, input bit typed,
                                    input table_beat_t want);
        stim_row_t row;
        row.cmd   = c;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endfunction

    // Search-and-append for messages; top-down sweep with move-last for aging
    function automatic table_beat_t apply_command(input nbt_pkg::cmd_t c);
        table_beat_t r;
        bit hit;
        int last;
        r = '0;
        hit = 1'b0;
        if (c.kind == nbt_pkg::CMD_MSG)
        begin
            for (int i = 0; i < nb_count; i++)
                if (nb_ident[i] == c.sender_id)
                    hit = 1'b1;
            if (hit)
                r.was_present = 1'b1;
            else if (nb_count < DEPTH)
            begin
                nb_ident[nb_count]    = c.sender_id;
                nb_stamp[nb_count]    = c.now;
                nb_distance[nb_count] = c.link_distance;
                nb_reported[nb_count] = c.sender_neighbors;
                nb_count++;
                r.was_inserted = 1'b1;
            end
            else
                r.was_dropped = 1'b1;
        end
        else
        begin
            for (int i = nb_count - 1; i >= 0; i--)
            begin
                if (i < nb_count && nbt_pkg::TICK_W'(c.now - nb_stamp[i]) >
                    nbt_pkg::TICK_W'(age_limit))
                begin
                    last = nb_count - 1;
                    nb_ident[i]    = nb_ident[last];
                    nb_stamp[i]    = nb_stamp[last];
                    nb_distance[i] = nb_distance[last];
                    nb_reported[i] = nb_reported[last];
                    nb_count--;
                    r.removed_count = r.removed_count + 1'b1;
                end
            end
        end
        r.table_count = CNT_W'(nb_count);
        return r;
    endfunction

    // Traffic that stays near the timeout so sweeps remove a share of entries
    function automatic nbt_pkg::cmd_t random_command(input int tmo);
        nbt_pkg::cmd_t c;
        int r;
        r = $urandom_range(0, 99);
        if (r < 90)
            tick = tick + nbt_pkg::TICK_W'($urandom_range(0, tmo / 6 + 2));
        else if (r < 98)
            tick = tick + nbt_pkg::TICK_W'($urandom_range(0, 2 * tmo + 8));
        else
            tick = $urandom;
        c.kind             = ($urandom_range(0, 99) < 18) ? nbt_pkg::CMD_AGE
                                                          : nbt_pkg::CMD_MSG;
        c.now              = tick;
        c.sender_id        = ($urandom_range(0, 99) < 85)
                             ? nbt_pkg::ID_W'($urandom_range(0, 23))
                             : nbt_pkg::ID_W'($urandom_range(0, 255));
        c.sender_neighbors = nbt_pkg::BYTE_W'($urandom_range(0, 255));
        c.link_distance    = nbt_pkg::BYTE_W'($urandom_range(0, 255));
        return c;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
                 want);
        mismatch_count++;
    endtask

    task automatic send_command(input nbt_pkg::cmd_t c, input bit typed,
                                input table_beat_t want);
        table_beat_t pred;
        opcode           <= c.kind;
        now              <= c.now;
        sender_id        <= c.sender_id;
        sender_neighbors <= c.sender_neighbors;
        link_distance    <= c.link_distance;
        in_valid         <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pred = apply_command(c);
        pending_results.push_back(typed ? want : pred);
    endtask

    task automatic idle_source();
        int gap;
        gap = source_quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_timeout(input logic [nbt_pkg::TMO_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        age_limit = value;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!sink_quiet && $urandom_range(0, 4) == 0)
                stall_left = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result beat with nothing pending", 1, 0);
            else
            begin
                oldest = pending_results.pop_front();
                if (table_count !== oldest.table_count)
                    report_mismatch("table_count", table_count, oldest.table_count);
                if (was_present !== oldest.was_present)
                    report_mismatch("was_present", was_present, oldest.was_present);
                if (was_inserted !== oldest.was_inserted)
                    report_mismatch("was_inserted", was_inserted, oldest.was_inserted);
                if (was_dropped !== oldest.was_dropped)
                    report_mismatch("was_dropped", was_dropped, oldest.was_dropped);
                if (removed_count !== oldest.removed_count)
                    report_mismatch("removed_count", removed_count, oldest.removed_count);
            end
        end
    end

    initial
    begin
        logic [nbt_pkg::TMO_W-1:0] phase_tmo [PHASES];
        table_beat_t none;
        none = '0;

        // Empty sweep, first entry, hit, extremes of every field
        add_row(make_cmd(nbt_pkg::CMD_AGE, 32'd0, 8'd0, 8'd0, 8'd0), 1,
                make_beat(0, 0, 0, 0, 0));
        add_row(make_cmd(nbt_pkg::CMD_MSG, 32'd0, 8'd0, 8'd0, 8'd0), 1,
                make_beat(1, 0, 1, 0, 0));
        add_row(make_cmd(nbt_pkg::CMD_MSG, 32'd5, 8'd0, 8'd9, 8'd9), 1,
                make_beat(1, 1, 0, 0, 0));
        add_row(make_cmd(nbt_pkg::CMD_MSG, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF), 1,
                make_beat(2, 0, 1, 0, 0));
        // Age wraps past zero; the top entry goes first and moves onto itself
        add_row(make_cmd(nbt_pkg::CMD_AGE, 32'd32, 8'hFF, 8'hFF, 8'hFF), 0, none);
        add_row(make_cmd(nbt_pkg::CMD_AGE, 32'd33, 8'h00, 8'h00, 8'h00), 0, none);
        for (int i = 1; i <= DEPTH; i++)
            add_row(make_cmd(nbt_pkg::CMD_MSG, 32'd100, nbt_pkg::ID_W'(i),
                             nbt_pkg::BYTE_W'(i * 17), nbt_pkg::BYTE_W'(255 - i)),
                    0, none);
        // Full table: miss is dropped, hit still found, then sweep clears all
        add_row(make_cmd(nbt_pkg::CMD_MSG, 32'd101, 8'd200, 8'hA5, 8'h5A), 1,
                make_beat(DEPTH, 0, 0, 1, 0));
        add_row(make_cmd(nbt_pkg::CMD_MSG, 32'd102, 8'd5, 8'h5A, 8'hA5), 1,
                make_beat(DEPTH, 1, 0, 0, 0));
        add_row(make_cmd(nbt_pkg::CMD_AGE, 32'd133, 8'd0, 8'd0, 8'd0), 1,
                make_beat(0, 0, 0, 0, DEPTH));

        phase_tmo[0] = 16'd1;
        phase_tmo[1] = 16'hFFFF;
        phase_tmo[2] = 16'd0;
        phase_tmo[3] = nbt_pkg::TMO_W'($urandom_range(2, 400));
        phase_tmo[4] = nbt_pkg::TMO_W'($urandom_range(1, 65535));
        phase_tmo[5] = nbt_pkg::TIMEOUT_RESET;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (directed_rows[k])
        begin
            send_command(directed_rows[k].cmd, directed_rows[k].typed, directed_rows[k].want);
            idle_source();
        end
        drain_results();

        for (int p = 0; p < PHASES; p++)
        begin
            write_timeout(phase_tmo[p]);
            source_quiet = (p == 1);
            sink_quiet   = (p == 1);
            tick = (p == 3) ? 32'hFFFF_FF00 : $urandom;
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                send_command(random_command(int'(phase_tmo[p])), 0, none);
                // At mid-phase and at random, hold the source until the table has answered everything
                if (n == PHASE_LEN / 2 || $urandom_range(0, 49) == 0)
                    drain_results();
                else
                    idle_source();
            end
            drain_results();
            sink_quiet = 1'b0;
        end

        repeat (DRAIN_WAIT) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("result beats never delivered", 0, pending_results.size());
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/nbt_pkg.sv
hw/rtl/nbt_front.sv
hw/rtl/nbt_queue.sv
hw/rtl/nbt_back.sv
hw/rtl/neighbor_table_with_aging.sv
sim/neighbor_table_with_aging_test.sv
